[hdl/p2b_pkg.sv]
// Shared types, constants and helpers for the pixel-to-body projection block.
// No dependencies; imported by p2b_div and the top level of the block.
`default_nettype none

package p2b_pkg;

    // Camera and calibration store geometry
    localparam int NUM_CAMERAS = 4;
    localparam int CAM_AW      = 2;
    localparam int WORDS       = 16;
    localparam int WIDX_W      = 4;
    localparam int WORD_W      = 32;
    localparam int EXT_N       = 12;

    // Calibration word indexes
    localparam logic [WIDX_W-1:0] WORD_FX   = 4'd0;
    localparam logic [WIDX_W-1:0] WORD_FY   = 4'd1;
    localparam logic [WIDX_W-1:0] WORD_CX   = 4'd2;
    localparam logic [WIDX_W-1:0] WORD_CY   = 4'd3;
    localparam int                WORD_EXT0 = 4;
    localparam logic [WIDX_W-1:0] WORD_R00  = 4'd4;
    localparam logic [WIDX_W-1:0] WORD_TX   = 4'd7;
    localparam logic [WIDX_W-1:0] WORD_R11  = 4'd9;
    localparam logic [WIDX_W-1:0] WORD_TY   = 4'd11;
    localparam logic [WIDX_W-1:0] WORD_R22  = 4'd14;
    localparam logic [WIDX_W-1:0] WORD_TZ   = 4'd15;
    localparam logic [3:0]        INTR_ALL  = 4'hF;

    localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Transaction modes
    localparam logic MODE_DETECT = 1'b0;
    localparam logic MODE_CALIB  = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TARGET_HEIGHT = 2'd0,
        REG_MAX_DEPTH     = 2'd1,
        REG_CAMERAS       = 2'd2
    } reg_idx_t;

    localparam logic [15:0] TARGET_HEIGHT_RST = 16'd3604;
    localparam logic [24:0] MAX_DEPTH_RST     = 25'd1310720;
    localparam logic [2:0]  CAMERAS_RST       = 3'd4;
    localparam logic [15:0] MIN_BOX           = 16'd16;
    localparam int          DEPTH_W           = 25;

    // Divider geometry: dividend magnitude, divisor, quotient bits, stages
    localparam int DIV_NW  = 58;
    localparam int DIV_DW  = 32;
    localparam int DIV_QW  = 33;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // Context carried alongside the depth division
    typedef struct packed {
        logic                        fail;
        logic [15:0]                 px;
        logic [15:0]                 py;
        logic [WORD_W-1:0]           fx;
        logic [WORD_W-1:0]           fy;
        logic [WORD_W-1:0]           cx;
        logic [WORD_W-1:0]           cy;
        logic [EXT_N-1:0][WORD_W-1:0] ext;
    } dctx_t;

    // Context carried alongside the camera-frame divisions
    typedef struct packed {
        logic                        fail;
        logic                        sx;
        logic                        sy;
        logic [DEPTH_W-1:0]          depth;
        logic [EXT_N-1:0][WORD_W-1:0] ext;
    } xctx_t;

    // Value of a calibration word that was never written
    function automatic logic [WORD_W-1:0] word_reset(input logic [WIDX_W-1:0] idx);
        logic [WORD_W-1:0] r;
        r = '0;
        if (idx == WORD_R00 || idx == WORD_R11 || idx == WORD_R22) begin
            r = ONE_Q16;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/p2b_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module p2b_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/p2b_div.sv]
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
// Depends on p2b_pkg for the operand widths and stage count.
`default_nettype none

module p2b_div import p2b_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_QW-1:0] quo,
    output logic              ovf
);
    localparam int HI_W = DIV_NW - DIV_QW;

    logic [DIV_DW-1:0] rem_reg [DIV_LAT];
    logic [DIV_QW-1:0] low_reg [DIV_LAT];
    logic [DIV_QW-1:0] q_reg   [DIV_LAT];
    logic [DIV_DW-1:0] den_reg [DIV_LAT];
    logic              ovf_reg [DIV_LAT];
    logic [HI_W-1:0]   num_hi;

    assign num_hi = num[DIV_NW-1:DIV_QW];

    // Load: flag quotients that do not fit, start remainder from the high part
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (DIV_DW'(num_hi) >= den);
            rem_reg[0] <= DIV_DW'(num_hi);
            low_reg[0] <= num[DIV_QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    // One subtract-and-compare step per stage
    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_step
        logic [DIV_DW:0] trial;
        logic [DIV_DW:0] diff;
        logic            ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][DIV_QW-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                low_reg[k] <= {low_reg[k-1][DIV_QW-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][DIV_QW-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = q_reg[DIV_LAT-1];
    assign ovf = ovf_reg[DIV_LAT-1] | (|rem_reg[DIV_LAT-1] & 1'b0) | (|low_reg[DIV_LAT-1] & 1'b0);

endmodule

`default_nettype wire

[hdl/pixel_to_body_projection_top.sv]
// Pixel-to-body projection: pinhole back-projection and camera-to-body transform.
// Depends on p2b_pkg, p2b_ram (calibration words) and p2b_div (depth and ray divides).
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one transaction per accepted edge.
//    mode 0 projects a detection and yields one result; mode 1 writes one
//    calibration word (camera, word_index, word_value) and yields nothing.
//  - Output channel (out_valid / out_stall) returns ok and body_x/y/z in Q16.16;
//    a failed detection returns ok 0 with all coordinates zero.
//  - Configuration (wr_en, wr_index, wr_data) sets target height, maximum depth
//    and the number of cameras in use; write it only while the block is idle.
//  - Throughput: one transaction per cycle while no blocked result stalls the
//    input. Calibration words sit in sixteen word-wide RAMs read together by
//    camera, so every detection gets its full calibration in a single read.
//  - Path: an accepted detection passes through the RAM read, focal product, a
//    34-stage depth divider, ray product, a 34-stage ray divider, the rotation
//    products, truncation and the output register.
//  - Reset clears all pipeline valids and the per-word written flags, so every
//    camera reads zero intrinsics and an identity extrinsic; no sweep is needed.
//  - When the receiver stalls, the result holds in the output register and the
//    pipeline keeps moving until a valid result reaches its last stage.
`default_nettype none

module pixel_to_body_projection_top import p2b_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [24:0]        wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [1:0]         camera,
    input  logic [15:0]        pixel_x,
    input  logic [15:0]        pixel_y,
    input  logic [15:0]        box_height,
    input  logic [3:0]         word_index,
    input  logic signed [31:0] word_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [31:0] body_x,
    output logic signed [31:0] body_y,
    output logic signed [31:0] body_z
);

    // Saturate a sign-magnitude quotient to signed 32 bits
    function automatic logic signed [31:0] sat_quo(input logic neg, input logic ov,
                                                   input logic [DIV_QW-1:0] q);
        logic signed [31:0] r;
        if (!neg)
        begin
            r = (ov || q[32] || q[31]) ? INT32_MAX : q[31:0];
        end
        else
        begin
            r = (ov || q[32] || (q[31:0] > 32'h8000_0000)) ? INT32_MIN : -q[31:0];
        end
        return r;
    endfunction

    // Divide a product by 65536, rounding toward zero
    function automatic logic [47:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p[63] ? (p + 64'sd65535) : p;
        return adj[63:16];
    endfunction

    // Saturate a 50-bit sum to signed 32 bits
    function automatic logic signed [31:0] sat50(input logic [49:0] s);
        logic signed [31:0] r;
        if (!s[49] && (|s[48:31]))
        begin
            r = INT32_MAX;
        end
        else if (s[49] && !(&s[48:31]))
        begin
            r = INT32_MIN;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [15:0] th_reg;
    logic [24:0] maxd_reg;
    logic [2:0]  cams_reg;

    // Handshake
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic accept;
    logic cam_exists;
    logic cam_in_use;
    logic wr_go;
    logic det_go;
    logic [CAM_AW-1:0] cam_addr;

    // Written flags per calibration word
    logic [WORDS-1:0] ent_vld_reg [NUM_CAMERAS];
    logic [WORDS-1:0][WORD_W-1:0] ram_q;

    // Stage A
    logic              a_vld_reg;
    logic              a_fail_reg;
    logic [15:0]       a_px_reg;
    logic [15:0]       a_py_reg;
    logic [15:0]       a_box_reg;
    logic [WORDS-1:0]  a_ent_reg;

    // Stage B
    logic [WORD_W-1:0] w [WORDS];
    dctx_t             b_in;
    logic              b_vld_reg;
    dctx_t             b_ctx_reg;
    logic [47:0]       b_num_reg;
    logic [15:0]       b_box_reg;

    // Depth division
    logic [DIV_QW-1:0]  dq;
    logic               dovf;
    logic [DIV_LAT-1:0] dl_vld_reg;
    dctx_t              dl_reg [DIV_LAT];
    dctx_t              dd;
    logic               depth_bad;

    // Stage D
    dctx_t              d_in;
    logic               d_vld_reg;
    dctx_t              d_ctx_reg;
    logic [DEPTH_W-1:0] d_depth_reg;
    logic signed [33:0] d_dx_reg;
    logic signed [33:0] d_dy_reg;

    // Stage E
    logic               e_vld_reg;
    logic signed [59:0] e_xprod_reg;
    logic signed [59:0] e_yprod_reg;
    logic [WORD_W-1:0]  e_fx_reg;
    logic [WORD_W-1:0]  e_fy_reg;
    logic               e_fail_reg;
    logic [DEPTH_W-1:0] e_depth_reg;
    logic [EXT_N-1:0][WORD_W-1:0] e_ext_reg;

    // Ray division
    logic [59:0]        xmag;
    logic [59:0]        ymag;
    logic [DIV_DW-1:0]  fxmag;
    logic [DIV_DW-1:0]  fymag;
    xctx_t              x_in;
    logic [DIV_QW-1:0]  xq;
    logic               xovf;
    logic [DIV_QW-1:0]  yq;
    logic               yovf;
    logic [DIV_LAT-1:0] xl_vld_reg;
    xctx_t              xl_reg [DIV_LAT];
    xctx_t              xx;

    // Stage G
    logic               g_vld_reg;
    logic               g_fail_reg;
    logic signed [31:0] g_cam_reg [3];
    logic [EXT_N-1:0][WORD_W-1:0] g_ext_reg;

    // Stage H
    logic               h_vld_reg;
    logic               h_fail_reg;
    logic signed [63:0] h_prod_reg [3][3];
    logic [WORD_W-1:0]  h_t_reg [3];

    // Stage I
    logic               i_vld_reg;
    logic               i_fail_reg;
    logic [47:0]        i_term_reg [3][3];
    logic [WORD_W-1:0]  i_t_reg [3];
    logic [49:0]        sum [3];

    // Output register
    logic               ok_reg;
    logic signed [31:0] body_x_reg;
    logic signed [31:0] body_y_reg;
    logic signed [31:0] body_z_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_reg   <= TARGET_HEIGHT_RST;
            maxd_reg <= MAX_DEPTH_RST;
            cams_reg <= CAMERAS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_TARGET_HEIGHT: th_reg   <= wr_data[15:0];
                REG_MAX_DEPTH:     maxd_reg <= wr_data;
                REG_CAMERAS:       cams_reg <= wr_data[2:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a valid result is blocked at the end
    assign out_free   = !out_valid_reg || !out_stall;
    assign advance    = out_free || !i_vld_reg;
    assign in_stall   = !advance;
    assign accept     = in_valid && advance;
    assign cam_addr   = camera[CAM_AW-1:0];
    assign cam_exists = (int'(camera) < NUM_CAMERAS);
    assign cam_in_use = ({1'b0, camera} < cams_reg);
    assign wr_go      = accept && (mode == MODE_CALIB) && cam_exists;
    assign det_go     = accept && (mode == MODE_DETECT);

    // Track which calibration words have been written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CAMERAS; c++)
            begin
                ent_vld_reg[c] <= '0;
            end
        end
        else if (wr_go)
        begin
            ent_vld_reg[cam_addr][word_index] <= 1'b1;
        end
    end

    // Calibration store: one RAM per word, all read at the camera address
    for (genvar k = 0; k < WORDS; k++)
    begin : g_store
        p2b_ram #(
            .WIDTH (WORD_W),
            .DEPTH (NUM_CAMERAS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_go && (word_index == WIDX_W'(k))),
            .waddr (cam_addr),
            .wdata (word_value),
            .re    (advance),
            .raddr (cam_addr),
            .rdata (ram_q[k])
        );
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            dl_vld_reg <= '0;
            d_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            xl_vld_reg <= '0;
            g_vld_reg  <= 1'b0;
            h_vld_reg  <= 1'b0;
            i_vld_reg  <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg  <= det_go;
            b_vld_reg  <= a_vld_reg;
            dl_vld_reg <= {dl_vld_reg[DIV_LAT-2:0], b_vld_reg};
            d_vld_reg  <= dl_vld_reg[DIV_LAT-1];
            e_vld_reg  <= d_vld_reg;
            xl_vld_reg <= {xl_vld_reg[DIV_LAT-2:0], e_vld_reg};
            g_vld_reg  <= xl_vld_reg[DIV_LAT-1];
            h_vld_reg  <= g_vld_reg;
            i_vld_reg  <= h_vld_reg;
        end
    end

    // Stage A: capture the detection and the early failure checks
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_fail_reg <= !cam_exists || !cam_in_use
                          || (ent_vld_reg[cam_addr][3:0] != INTR_ALL)
                          || (box_height < MIN_BOX);
            a_px_reg   <= pixel_x;
            a_py_reg   <= pixel_y;
            a_box_reg  <= box_height;
            a_ent_reg  <= ent_vld_reg[cam_addr];
        end
    end

    // Stage B: resolve unwritten words to their reset values, check the focal lengths
    always_comb
    begin
        for (int k = 0; k < WORDS; k++)
        begin
            w[k] = a_ent_reg[k] ? ram_q[k] : word_reset(WIDX_W'(k));
        end
        b_in.fail = a_fail_reg || (w[WORD_FX] == '0)
                    || w[WORD_FY][WORD_W-1] || (w[WORD_FY] == '0);
        b_in.px = a_px_reg;
        b_in.py = a_py_reg;
        b_in.fx = w[WORD_FX];
        b_in.fy = w[WORD_FY];
        b_in.cx = w[WORD_CX];
        b_in.cy = w[WORD_CY];
        for (int i = 0; i < EXT_N; i++)
        begin
            b_in.ext[i] = w[WORD_EXT0 + i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_ctx_reg <= b_in;
            b_num_reg <= 48'(w[WORD_FY]) * 48'(th_reg);
            b_box_reg <= a_box_reg;
        end
    end

    // Depth = floor(fy * height / 4096 / box)
    p2b_div u_depth_div (
        .clk (clk),
        .en  (advance),
        .num (DIV_NW'(b_num_reg[47:12])),
        .den (DIV_DW'(b_box_reg)),
        .quo (dq),
        .ovf (dovf)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dl_reg[0] <= b_ctx_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    // Stage D: range-check depth, offset the centre by the principal point
    assign dd        = dl_reg[DIV_LAT-1];
    assign depth_bad = dovf || (dq == '0) || (dq > DIV_QW'(maxd_reg));

    always_comb
    begin
        d_in      = dd;
        d_in.fail = dd.fail || depth_bad;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_ctx_reg      <= d_in;
            d_depth_reg    <= dq[DEPTH_W-1:0];
            d_dx_reg       <= $signed({6'b0, dd.px, 12'b0})
                              - $signed({{2{dd.cx[31]}}, dd.cx});
            d_dy_reg       <= $signed({6'b0, dd.py, 12'b0})
                              - $signed({{2{dd.cy[31]}}, dd.cy});
        end
    end

    // Stage E: scale the offsets by depth
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_xprod_reg <= $signed({1'b0, d_depth_reg}) * d_dx_reg;
            e_yprod_reg <= $signed({1'b0, d_depth_reg}) * d_dy_reg;
            e_fx_reg    <= d_ctx_reg.fx;
            e_fy_reg    <= d_ctx_reg.fy;
            e_fail_reg  <= d_ctx_reg.fail;
            e_depth_reg <= d_depth_reg;
            e_ext_reg   <= d_ctx_reg.ext;
        end
    end

    // Divide magnitudes and keep the quotient signs aside
    always_comb
    begin
        xmag    = e_xprod_reg[59] ? 60'(-e_xprod_reg) : 60'(e_xprod_reg);
        ymag    = e_yprod_reg[59] ? 60'(-e_yprod_reg) : 60'(e_yprod_reg);
        fxmag   = e_fx_reg[31] ? (~e_fx_reg + 32'd1) : e_fx_reg;
        fymag   = e_fy_reg[31] ? (~e_fy_reg + 32'd1) : e_fy_reg;
        x_in.fail  = e_fail_reg;
        x_in.sx    = e_xprod_reg[59] ^ e_fx_reg[31];
        x_in.sy    = e_yprod_reg[59] ^ e_fy_reg[31];
        x_in.depth = e_depth_reg;
        x_in.ext   = e_ext_reg;
    end

    p2b_div u_x_div (
        .clk (clk),
        .en  (advance),
        .num (xmag[DIV_NW-1:0]),
        .den (fxmag),
        .quo (xq),
        .ovf (xovf)
    );

    p2b_div u_y_div (
        .clk (clk),
        .en  (advance),
        .num (ymag[DIV_NW-1:0]),
        .den (fymag),
        .quo (yq),
        .ovf (yovf)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xl_reg[0] <= x_in;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                xl_reg[k] <= xl_reg[k-1];
            end
        end
    end

    // Stage G: camera-frame point, saturated
    assign xx = xl_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            g_fail_reg   <= xx.fail;
            g_cam_reg[0] <= sat_quo(xx.sx, xovf, xq);
            g_cam_reg[1] <= sat_quo(xx.sy, yovf, yq);
            g_cam_reg[2] <= $signed({7'b0, xx.depth});
            g_ext_reg    <= xx.ext;
        end
    end

    // Stage H: rotation products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h_fail_reg <= g_fail_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    h_prod_reg[r][c] <= $signed(g_ext_reg[4*r+c]) * g_cam_reg[c];
                end
                h_t_reg[r] <= g_ext_reg[4*r+3];
            end
        end
    end

    // Stage I: truncate each product toward zero
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            i_fail_reg <= h_fail_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    i_term_reg[r][c] <= trunc16(h_prod_reg[r][c]);
                end
                i_t_reg[r] <= h_t_reg[r];
            end
        end
    end

    // Add translation and terms
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = {{18{i_t_reg[r][31]}}, i_t_reg[r]}
                     + {{2{i_term_reg[r][0][47]}}, i_term_reg[r][0]}
                     + {{2{i_term_reg[r][1][47]}}, i_term_reg[r][1]}
                     + {{2{i_term_reg[r][2][47]}}, i_term_reg[r][2]};
        end
    end

    // Output register: load when free, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && i_vld_reg)
        begin
            ok_reg     <= !i_fail_reg;
            body_x_reg <= i_fail_reg ? '0 : sat50(sum[0]);
            body_y_reg <= i_fail_reg ? '0 : sat50(sum[1]);
            body_z_reg <= i_fail_reg ? '0 : sat50(sum[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign body_x    = body_x_reg;
    assign body_y    = body_y_reg;
    assign body_z    = body_z_reg;

endmodule

`default_nettype wire

[hdl/p2b_checker.sv]
// Port-level checks for the pixel-to-body projection top level, bound to it.
// No package dependencies.
`default_nettype none

module p2b_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               ok,
    input logic signed [31:0] body_x,
    input logic signed [31:0] body_y,
    input logic signed [31:0] body_z
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ok) && $stable(body_x)
                                   && $stable(body_y) && $stable(body_z))
        else $error("result changed while stalled");

    // A failed transaction reports zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> body_x == 0 && body_y == 0 && body_z == 0)
        else $error("failed result with nonzero coordinates");

    // Input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind pixel_to_body_projection_top p2b_port_checks u_p2b_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .body_x    (body_x),
    .body_y    (body_y),
    .body_z    (body_z)
);

`default_nettype wire
